### sv/mikh_pkg.sv
// mikh_pkg: shared types, constants and mixing functions for the
// multi-index key hash core; no dependencies
`default_nettype none

package mikh_pkg;

   localparam int WORD_W        = 32;
   localparam int LEN_W         = 6;
   localparam int MAX_KEY_WORDS = 32;
   localparam int HASH_BASE_W   = 16;

   localparam logic [LEN_W-1:0]  KEY_LEN_RESET = LEN_W'(1);
   localparam logic [WORD_W-1:0] GOLDEN        = 32'h9e37_79b9;

   // result queue sizing
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
   } acc_type;

   localparam acc_type ACC_INIT = '{a: GOLDEN, b: GOLDEN, c: '0};
   localparam acc_type ACC_ZERO = '{a: '0, b: '0, c: '0};

   function automatic acc_type acc_add(acc_type x, acc_type y);
      acc_type r;
      r.a = x.a + y.a;
      r.b = x.b + y.b;
      r.c = x.c + y.c;
      return r;
   endfunction

   // three lines of the lookup2 mix, shift amounts fixed per call site
   function automatic acc_type mix_round(acc_type x, logic [4:0] sa, logic [4:0] sb,
                                         logic [4:0] sc);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      acc_type r;
      a = x.a - x.b - x.c;
      a = a ^ (x.c >> sa);
      b = x.b - x.c - a;
      b = b ^ (a << sb);
      c = x.c - a - b;
      c = c ^ (b >> sc);
      r.a = a;
      r.b = b;
      r.c = c;
      return r;
   endfunction

   function automatic acc_type mix_r1(acc_type x);
      return mix_round(x, 5'd13, 5'd8, 5'd13);
   endfunction

   function automatic acc_type mix_r2(acc_type x);
      return mix_round(x, 5'd12, 5'd16, 5'd5);
   endfunction

   function automatic acc_type mix_r3(acc_type x);
      return mix_round(x, 5'd3, 5'd10, 5'd15);
   endfunction

   // zero counts as one word, anything past the maximum as the maximum
   function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] n);
      logic [LEN_W-1:0] r;
      r = n;
      if (n == '0) begin
         r = LEN_W'(1);
      end else if (n > LEN_W'(MAX_KEY_WORDS)) begin
         r = LEN_W'(MAX_KEY_WORDS);
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] hash_mask(logic [LEN_W-1:0] len);
      logic [LEN_W:0]    width;
      logic [WORD_W:0]   one_hot;
      logic [WORD_W-1:0] r;
      width   = (LEN_W + 1)'(len >> 1) + (LEN_W + 1)'(HASH_BASE_W);
      one_hot = (WORD_W + 1)'(1) << width;
      if (width >= (LEN_W + 1)'(WORD_W)) begin
         r = '1;
      end else begin
         r = one_hot[WORD_W-1:0] - WORD_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/mikh_out_fifo.sv
// mikh_out_fifo: small result queue between the final mix pipeline and the
// response channel; depends on mikh_pkg
`default_nettype none

module mikh_out_fifo
   import mikh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire logic [WORD_W-1:0] push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output logic [WORD_W-1:0]      pop_data
);

   logic [WORD_W-1:0]    mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff;
   logic [OUT_PTR_W-1:0] rd_ptr_ff;
   logic [OUT_CNT_W-1:0] cnt_ff;
   logic                 pop_fire;

   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign pop_fire  = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
         case ({push_valid, pop_fire})
            2'b10:   cnt_ff <= cnt_ff + OUT_CNT_W'(1);
            2'b01:   cnt_ff <= cnt_ff - OUT_CNT_W'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/multi_index_key_hash_core.sv
// multi_index_key_hash_core: lookup2 bucket hash over multi-word keys
// depends on mikh_pkg and mikh_out_fifo
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   request | req_valid req_ready req_key_word   | in
//   result  | rsp_valid rsp_ready rsp_bucket_index| out
//   config  | csr_we csr_wdata (key_length)      | in
//
// one key word is taken per cycle while req_ready is high; a result leaves
// the final mix after the key's last word, once any group mix of it is done.
// the group mix is an iterative unit, which a group of three words never
// outruns; the final mix is a 3-stage pipeline into an 8-entry queue.
// req_ready drops only when 8 results are queued or in flight.
// synchronous reset sets key_length to 1 and clears any partial key.
`default_nettype none

module multi_index_key_hash_core
   import mikh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [WORD_W-1:0] req_key_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WORD_W-1:0]      rsp_bucket_index,
   input  wire logic              csr_we,
   input  wire logic [LEN_W-1:0]  csr_wdata
);

   // group mix phase codes
   localparam logic [1:0] GPH_IDLE = 2'd0;
   localparam logic [1:0] GPH_R2   = 2'd1;
   localparam logic [1:0] GPH_R3   = 2'd2;
   localparam logic [1:0] GPH_DONE = 2'd3;

   localparam logic [1:0] POS_LAST = 2'd2;

   logic [LEN_W-1:0]     key_length_ff;
   acc_type              acc_ff;
   logic [LEN_W-1:0]     ws_ff;
   logic [1:0]           pos_ff;
   acc_type              g_ff;
   acc_type              g_in;
   logic [1:0]           gph_ff;
   logic                 gfin_ff;
   acc_type              fwait_ff;
   acc_type              f1_ff;
   acc_type              f2_ff;
   logic                 f1v_ff;
   logic                 f2v_ff;
   logic [OUT_CNT_W-1:0] res_ff;

   logic [LEN_W-1:0]  len_eff;
   logic              req_accept;
   logic              pend;
   logic              fold;
   acc_type           base;
   acc_type           sum;
   acc_type           len_acc;
   logic              grp_done;
   logic [LEN_W-1:0]  ws_inc;
   logic              last;
   logic              g_launch;
   logic              fin_from_g;
   logic              fin_direct;
   logic              fin_launch;
   logic              set_wait;
   acc_type           fin_in;
   acc_type           f_out;
   logic [WORD_W-1:0] push_data;
   logic              res_inc;
   logic              res_dec;

   assign len_eff    = eff_len(key_length_ff);
   assign req_ready  = (res_ff < OUT_CNT_W'(OUT_DEPTH));
   assign req_accept = req_valid && req_ready;

   // front-end accumulators hold only the words added since a group mix
   // started until that mix finishes and gets folded back in
   assign pend = ((gph_ff == GPH_R2) || (gph_ff == GPH_R3)) && !gfin_ff;
   assign fold = (gph_ff == GPH_DONE) && !gfin_ff;
   assign base = fold ? acc_add(acc_ff, g_ff) : acc_ff;

   always_comb begin
      sum = base;
      case (pos_ff)
         2'd0:    sum.a = base.a + req_key_word;
         2'd1:    sum.b = base.b + req_key_word;
         default: sum.c = base.c + req_key_word;
      endcase
   end

   assign len_acc  = '{a: '0, b: '0, c: WORD_W'(len_eff)};
   assign grp_done = (pos_ff == POS_LAST);
   assign ws_inc   = ws_ff + LEN_W'(1);
   assign last     = (ws_inc >= len_eff);

   assign g_launch   = req_accept && grp_done;
   assign fin_from_g = (gph_ff == GPH_DONE) && gfin_ff;
   assign fin_direct = req_accept && last && !grp_done && !pend;
   assign set_wait   = req_accept && last && (grp_done || pend);
   assign fin_launch = fin_from_g || fin_direct;
   assign fin_in     = fin_from_g ? acc_add(g_ff, fwait_ff) : acc_add(sum, len_acc);

   always_comb begin
      g_in = g_ff;
      if (g_launch) begin
         g_in = mix_r1(sum);
      end else if (gph_ff == GPH_R2) begin
         g_in = mix_r2(g_ff);
      end else if (gph_ff == GPH_R3) begin
         g_in = mix_r3(g_ff);
      end
   end

   assign f_out     = mix_r3(f2_ff);
   assign push_data = f_out.c & hash_mask(len_eff);
   assign res_inc   = req_accept && last;
   assign res_dec   = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_RESET;
         acc_ff        <= ACC_INIT;
         ws_ff         <= '0;
         pos_ff        <= '0;
         gph_ff        <= GPH_IDLE;
         gfin_ff       <= 1'b0;
         f1v_ff        <= 1'b0;
         f2v_ff        <= 1'b0;
         res_ff        <= '0;
      end else begin
         if (csr_we) begin
            key_length_ff <= csr_wdata;
            acc_ff        <= ACC_INIT;
            ws_ff         <= '0;
            pos_ff        <= '0;
         end else if (req_accept) begin
            if (last) begin
               acc_ff <= ACC_INIT;
               ws_ff  <= '0;
               pos_ff <= '0;
            end else if (grp_done) begin
               acc_ff <= ACC_ZERO;
               ws_ff  <= ws_inc;
               pos_ff <= '0;
            end else begin
               acc_ff <= sum;
               ws_ff  <= ws_inc;
               pos_ff <= pos_ff + 2'd1;
            end
         end else if (fold) begin
            acc_ff <= base;
         end

         if (g_launch) begin
            gph_ff <= GPH_R2;
         end else begin
            case (gph_ff)
               GPH_R2:  gph_ff <= GPH_R3;
               GPH_R3:  gph_ff <= GPH_DONE;
               default: gph_ff <= GPH_IDLE;
            endcase
         end

         // gfin marks a group mix whose result feeds the final mix
         if (g_launch) begin
            gfin_ff <= last;
         end else if (set_wait) begin
            gfin_ff <= 1'b1;
         end else if (fin_from_g) begin
            gfin_ff <= 1'b0;
         end

         f1v_ff <= fin_launch;
         f2v_ff <= f1v_ff;

         case ({res_inc, res_dec})
            2'b10:   res_ff <= res_ff + OUT_CNT_W'(1);
            2'b01:   res_ff <= res_ff - OUT_CNT_W'(1);
            default: res_ff <= res_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      g_ff  <= g_in;
      f1_ff <= mix_r1(fin_in);
      f2_ff <= mix_r2(f1_ff);
      if (set_wait) begin
         fwait_ff <= grp_done ? len_acc : acc_add(sum, len_acc);
      end
   end

   mikh_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f2v_ff),
      .push_data  (push_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_bucket_index)
   );

   // a group mix only starts once the previous one is finished
   a_group_free: assert property (@(posedge clock) disable iff (reset)
      g_launch |-> ((gph_ff == GPH_IDLE) || (gph_ff == GPH_DONE)))
      else $error("group mix launched while busy");

   a_one_final: assert property (@(posedge clock) disable iff (reset)
      fin_from_g |-> !fin_direct)
      else $error("two final mixes launched in one cycle");

   a_wait_free: assert property (@(posedge clock) disable iff (reset)
      set_wait |-> (!gfin_ff || fin_from_g))
      else $error("pending final mix overwritten");

   a_credit_cap: assert property (@(posedge clock) disable iff (reset)
      res_ff <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result credits exceeded");

   a_rsp_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (res_ff != '0))
      else $error("result shown without a reserved slot");

endmodule

`default_nettype wire
